// File: rtl/core/sacs_pkg.sv
// types and constants shared by the sprite cel selector
`default_nettype none
package sacs_pkg;

  localparam logic [23:0] TOTAL_MAX = 24'hFFFFFF;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_PREPARE = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_ANIM_MODE   = 3'd0,
    REG_FRAME_DELAY = 3'd1,
    REG_CEL_COUNT   = 3'd2,
    REG_BEGIN_DELAY = 3'd3,
    REG_END_DELAY   = 3'd4
  } reg_idx_e;

  localparam logic [1:0] MODE_LOOP     = 2'd0;
  localparam logic [1:0] MODE_ONCE     = 2'd1;
  localparam logic [1:0] MODE_PINGPONG = 2'd2;
  // unassigned mode, runs as loop
  localparam logic [1:0] MODE_RSVD     = 2'd3;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  entry_index;
    logic [15:0] delay_value;
    logic [31:0] query_time;
  } item_t;

  typedef struct packed {
    logic [1:0]  anim_mode;
    logic [15:0] frame_delay;
    logic [7:0]  cel_count;
    logic [15:0] begin_delay;
    logic [15:0] end_delay;
  } cfg_t;

  // back end control seen by the front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/sacs_front.sv
// command intake: decodes a word and queues it for the back end
`default_nettype none
module sacs_front import sacs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [7:0]  entry_index_i,
  input  wire logic [15:0] delay_value_i,
  input  wire logic [31:0] query_time_i,
  input  wire bk_ctl_t     bk_ctl_i,
  output logic             busy_o,
  output logic             q_valid_o,
  output item_t            q_item_o
);

  item_t      fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;
  item_t      item;

  assign busy_o = (count_q == 2'd2) || bk_ctl_i.clearing;
  assign push   = start_i && !busy_o;
  assign pop    = bk_ctl_i.pop && (count_q != 2'd0);

  always_comb begin
    item.cmd         = cmd_e'(cmd_i);
    item.entry_index = entry_index_i;
    item.delay_value = delay_value_i;
    item.query_time  = query_time_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= 1'b0;
      rd_ptr_q  <= 1'b0;
      count_q   <= 2'd0;
      fifo_q[0] <= '0;
      fifo_q[1] <= '0;
    end else begin
      if (push) begin
        fifo_q[wr_ptr_q] <= item;
        wr_ptr_q         <= !wr_ptr_q;
      end
      if (pop) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

  assign q_valid_o = (count_q != 2'd0);
  assign q_item_o  = fifo_q[rd_ptr_q];

endmodule
`default_nettype wire

// File: rtl/core/sacs_div.sv
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none
module sacs_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        go_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [23:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      quot_o,
  output logic [23:0]      rem_o
);

  logic [31:0] quot_q;
  logic [23:0] rem_q, dvs_q;
  logic [5:0]  cnt_q;
  logic        run_q, done_q;
  logic [24:0] trial;
  logic        fits;

  assign trial = {rem_q, quot_q[31]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        quot_q <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        cnt_q  <= 6'd32;
        run_q  <= 1'b1;
      end else if (run_q) begin
        rem_q  <= fits ? 24'(trial - {1'b0, dvs_q}) : trial[23:0];
        quot_q <= {quot_q[30:0], fits};
        cnt_q  <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// File: rtl/core/sacs_back.sv
// execution engine: delay table, prepare sweep and query walk
`default_nettype none
module sacs_back import sacs_pkg::*; #(
  parameter int MAX_FRAMES = 256
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  q_valid_i,
  input  wire item_t q_item_i,
  output bk_ctl_t    bk_ctl_o,
  output logic       done_o,
  output logic [7:0] image_cel_o,
  output logic [7:0] anim_frame_o,
  output logic [23:0] total_time_o,
  output logic       status_o
);

  localparam int AW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FW  = $clog2(MAX_FRAMES + 1);
  localparam int SW  = 16 + FW;
  localparam int MRW = ((FW > 9) ? FW : 9) + 1;

  typedef enum logic [11:0] {
    S_CLEAR      = 12'b000000000001,
    S_IDLE       = 12'b000000000010,
    S_PREP_BEG   = 12'b000000000100,
    S_PREP_END   = 12'b000000001000,
    S_PREP_SWEEP = 12'b000000010000,
    S_PREP_MUL   = 12'b000000100000,
    S_PREP_FIN   = 12'b000001000000,
    S_Q_MOD      = 12'b000010000000,
    S_Q_DIV      = 12'b000100000000,
    S_Q_FRM      = 12'b001000000000,
    S_Q_WALK     = 12'b010000000000,
    S_RESP       = 12'b100000000000
  } state_e;

  state_e state_q;

  logic [15:0] mem [MAX_FRAMES];
  logic [15:0] mem_rdata_q;
  logic        mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [15:0] mem_wd;

  logic [FW-1:0] cnt_q, frames_q, pf_q;
  logic          pend_q;
  logic [AW-1:0] pend_idx_q, frame_q;
  logic [SW-1:0] acc_q;
  logic [23:0]   total_q, tred_q;
  logic          present_q, prepared_q, mirror_on_q, pp_q;
  logic [7:0]    mcels_q, n_q;

  logic          div_go_q, div_done;
  logic [31:0]   div_dvd_q, div_quot;
  logic [23:0]   div_dvs_q, div_rem;

  logic          done_q, status_q;
  logic [7:0]    cel_q, aframe_q;
  logic [23:0]   tot_out_q;

  logic [15:0]   fd_eff;
  logic [7:0]    n_eff;
  logic          pp_eff;
  logic [8:0]    fr_raw;
  logic [FW-1:0] fr_clamp;
  logic          issue_sweep, issue_walk, in_range;
  logic [SW-1:0] sweep_add, walk_acc;
  logic [23:0]   sat_total;
  logic [MRW-1:0] f_ext, mc_ext, mir;

  assign fd_eff   = (cfg_i.frame_delay == 16'd0) ? 16'd1 : cfg_i.frame_delay;
  assign n_eff    = (cfg_i.cel_count == 8'd0) ? 8'd1 : cfg_i.cel_count;
  assign pp_eff   = (cfg_i.anim_mode == MODE_PINGPONG) && (n_eff > 8'd1);
  assign fr_raw   = pp_eff ? ({n_eff, 1'b0} - 9'd2) : {1'b0, n_eff};
  assign fr_clamp = (32'(fr_raw) > 32'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : FW'(fr_raw);
  assign in_range = 32'(q_item_i.entry_index) < 32'(MAX_FRAMES);

  assign issue_sweep = cnt_q < FW'(MAX_FRAMES);
  assign issue_walk  = cnt_q < frames_q;
  // unset entries inside the pass take the uniform delay
  assign sweep_add   = (mem_rdata_q == 16'd0) ? SW'(fd_eff) : SW'(mem_rdata_q);
  assign walk_acc    = acc_q + SW'(mem_rdata_q);
  assign sat_total   = (32'(acc_q) > 32'(TOTAL_MAX)) ? TOTAL_MAX : 24'(acc_q);

  // ping-pong folds the back half of the pass onto the cels
  assign f_ext  = MRW'(frame_q);
  assign mc_ext = MRW'(mcels_q);
  assign mir    = (mirror_on_q && (f_ext >= mc_ext)) ? ((mc_ext << 1) - MRW'(2) - f_ext)
                                                     : f_ext;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cnt_q[AW-1:0];
    mem_wd = 16'd0;
    mem_ra = cnt_q[AW-1:0];
    unique case (state_q)
      S_CLEAR: mem_we = 1'b1;
      S_IDLE: begin
        mem_wa = AW'(q_item_i.entry_index);
        mem_wd = q_item_i.delay_value;
        mem_we = q_valid_i && (q_item_i.cmd == CMD_WRITE) && in_range;
      end
      S_PREP_BEG: begin
        mem_wa = '0;
        mem_wd = cfg_i.begin_delay;
        mem_we = cfg_i.begin_delay != 16'd0;
      end
      S_PREP_END: begin
        mem_wa = AW'(pf_q - FW'(1));
        mem_wd = cfg_i.end_delay;
        mem_we = cfg_i.end_delay != 16'd0;
      end
      S_PREP_SWEEP: begin
        mem_wa = pend_idx_q;
        if (pend_q) begin
          if (32'(pend_idx_q) >= 32'(pf_q)) begin
            mem_we = 1'b1;
            mem_wd = 16'd0;
          end else if (mem_rdata_q == 16'd0) begin
            mem_we = 1'b1;
            mem_wd = fd_eff;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rdata_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      frames_q    <= '0;
      pf_q        <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      frame_q     <= '0;
      acc_q       <= '0;
      total_q     <= '0;
      tred_q      <= '0;
      present_q   <= 1'b0;
      prepared_q  <= 1'b0;
      mirror_on_q <= 1'b0;
      pp_q        <= 1'b0;
      mcels_q     <= 8'd1;
      n_q         <= 8'd1;
      div_go_q    <= 1'b0;
      div_dvd_q   <= '0;
      div_dvs_q   <= '0;
      done_q      <= 1'b0;
      status_q    <= 1'b0;
      cel_q       <= '0;
      aframe_q    <= '0;
      tot_out_q   <= '0;
    end else begin
      done_q   <= 1'b0;
      div_go_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + FW'(1);
          if (cnt_q == FW'(MAX_FRAMES - 1)) begin
            cnt_q   <= '0;
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid_i) begin
            case (q_item_i.cmd)
              CMD_PREPARE: begin
                n_q     <= n_eff;
                pp_q    <= pp_eff;
                pf_q    <= fr_clamp;
                state_q <= S_PREP_BEG;
              end
              CMD_QUERY: begin
                if (!prepared_q || (total_q == 24'd0) || (frames_q == '0)) begin
                  done_q    <= 1'b1;
                  status_q  <= 1'b1;
                  cel_q     <= '0;
                  aframe_q  <= '0;
                  tot_out_q <= '0;
                end else if ((cfg_i.anim_mode == MODE_ONCE) &&
                             (q_item_i.query_time >= 32'(total_q))) begin
                  frame_q <= AW'(frames_q - FW'(1));
                  state_q <= S_RESP;
                end else begin
                  div_go_q  <= 1'b1;
                  div_dvd_q <= q_item_i.query_time;
                  div_dvs_q <= total_q;
                  state_q   <= S_Q_MOD;
                end
              end
              default: begin
                if ((q_item_i.cmd == CMD_WRITE) && in_range) present_q <= 1'b1;
                done_q    <= 1'b1;
                status_q  <= 1'b0;
                cel_q     <= '0;
                aframe_q  <= '0;
                tot_out_q <= total_q;
              end
            endcase
          end
        end
        S_PREP_BEG: begin
          if (cfg_i.begin_delay != 16'd0) present_q <= 1'b1;
          state_q <= S_PREP_END;
        end
        S_PREP_END: begin
          if (cfg_i.end_delay != 16'd0) present_q <= 1'b1;
          cnt_q  <= '0;
          pend_q <= 1'b0;
          acc_q  <= '0;
          state_q <= (present_q || (cfg_i.end_delay != 16'd0)) ? S_PREP_SWEEP : S_PREP_MUL;
        end
        S_PREP_SWEEP: begin
          pend_q     <= issue_sweep;
          pend_idx_q <= cnt_q[AW-1:0];
          if (issue_sweep) cnt_q <= cnt_q + FW'(1);
          if (pend_q && (32'(pend_idx_q) < 32'(pf_q))) acc_q <= acc_q + sweep_add;
          if (!issue_sweep && !pend_q) state_q <= S_PREP_FIN;
        end
        S_PREP_MUL: begin
          acc_q   <= fd_eff * SW'(pf_q);
          state_q <= S_PREP_FIN;
        end
        S_PREP_FIN: begin
          total_q     <= sat_total;
          frames_q    <= pf_q;
          mirror_on_q <= pp_q;
          mcels_q     <= n_q;
          prepared_q  <= 1'b1;
          done_q      <= 1'b1;
          status_q    <= 1'b0;
          cel_q       <= '0;
          aframe_q    <= '0;
          tot_out_q   <= sat_total;
          state_q     <= S_IDLE;
        end
        S_Q_MOD: begin
          if (div_done) begin
            tred_q <= div_rem;
            if (present_q) begin
              cnt_q   <= '0;
              pend_q  <= 1'b0;
              acc_q   <= '0;
              state_q <= S_Q_WALK;
            end else begin
              div_go_q  <= 1'b1;
              div_dvd_q <= {8'd0, div_rem};
              div_dvs_q <= {8'd0, fd_eff};
              state_q   <= S_Q_DIV;
            end
          end
        end
        S_Q_DIV: begin
          if (div_done) begin
            div_go_q  <= 1'b1;
            div_dvd_q <= div_quot;
            div_dvs_q <= 24'(frames_q);
            state_q   <= S_Q_FRM;
          end
        end
        S_Q_FRM: begin
          if (div_done) begin
            frame_q <= div_rem[AW-1:0];
            state_q <= S_RESP;
          end
        end
        S_Q_WALK: begin
          pend_q     <= issue_walk;
          pend_idx_q <= cnt_q[AW-1:0];
          if (issue_walk) cnt_q <= cnt_q + FW'(1);
          if (pend_q) begin
            acc_q <= walk_acc;
            if (32'(walk_acc) > 32'(tred_q)) begin
              frame_q <= pend_idx_q;
              state_q <= S_RESP;
            end else if (32'(pend_idx_q) == 32'(frames_q) - 32'd1) begin
              frame_q <= pend_idx_q;
              state_q <= S_RESP;
            end
          end
        end
        S_RESP: begin
          done_q    <= 1'b1;
          status_q  <= 1'b0;
          cel_q     <= mir[7:0];
          aframe_q  <= 8'(frame_q);
          tot_out_q <= total_q;
          state_q   <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  sacs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (div_go_q),
    .dividend_i (div_dvd_q),
    .divisor_i  (div_dvs_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign bk_ctl_o.pop      = (state_q == S_IDLE);
  assign bk_ctl_o.clearing = (state_q == S_CLEAR);

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign image_cel_o  = cel_q;
  assign anim_frame_o = aframe_q;
  assign total_time_o = tot_out_q;

endmodule
`default_nettype wire

// File: rtl/core/sprite_animation_cel_select.sv
// top level of the sprite animation cel selector
`default_nettype none
// usage:
//  - command channel: a word is taken on a clock edge with start high and
//    busy low; cmd picks write delay, prepare or query
//  - every word gives one result word, shown for one cycle with done_o high;
//    the receiver cannot hold it off, so capture it on that edge
//  - a two-entry queue sits between intake and execution, so start may be
//    raised again while the engine still works
//  - flow: write and no-op are answered from idle; prepare makes one pass
//    over the delay memory (one entry per cycle, single read port) or one
//    multiply with no delays stored; query answers from idle before any
//    prepare, goes straight to the result when held at the end, takes the
//    remainder in the bit-serial divider then walks the table with stored
//    delays, or makes three divider runs on the uniform path
//  - config port: cfg_valid_i/cfg_index_i/cfg_data_i, always ready; write
//    only when the block is idle
//  - reset: registers take their defaults, then a clearing pass over all
//    MAX_FRAMES entries zeros the delay memory while busy stays high
module sprite_animation_cel_select import sacs_pkg::*; #(
  parameter int MAX_FRAMES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [7:0]  entry_index_i,
  input  wire logic [15:0] delay_value_i,
  input  wire logic [31:0] query_time_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output logic             done_o,
  output logic [7:0]       image_cel_o,
  output logic [7:0]       anim_frame_o,
  output logic [23:0]      total_time_o,
  output logic             status_o
);

  cfg_t    cfg_q;
  logic    q_valid;
  item_t   q_item;
  bk_ctl_t bk_ctl;

  // config registers, one per index; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.anim_mode   <= MODE_LOOP;
      cfg_q.frame_delay <= 16'd1;
      cfg_q.cel_count   <= 8'd1;
      cfg_q.begin_delay <= 16'd0;
      cfg_q.end_delay   <= 16'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_ANIM_MODE:   cfg_q.anim_mode   <= cfg_data_i[1:0];
        REG_FRAME_DELAY: cfg_q.frame_delay <= cfg_data_i;
        REG_CEL_COUNT:   cfg_q.cel_count   <= cfg_data_i[7:0];
        REG_BEGIN_DELAY: cfg_q.begin_delay <= cfg_data_i;
        REG_END_DELAY:   cfg_q.end_delay   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // intake and queue
  sacs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .cmd_i         (cmd_i),
    .entry_index_i (entry_index_i),
    .delay_value_i (delay_value_i),
    .query_time_i  (query_time_i),
    .bk_ctl_i      (bk_ctl),
    .busy_o        (busy),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item)
  );

  // execution engine with the delay memory
  sacs_back #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .bk_ctl_o     (bk_ctl),
    .done_o       (done_o),
    .image_cel_o  (image_cel_o),
    .anim_frame_o (anim_frame_o),
    .total_time_o (total_time_o),
    .status_o     (status_o)
  );

endmodule
`default_nettype wire

// File: rtl/core/sacs_checker.sv
// port-level checks for the cel selector and their binding
`default_nettype none
module sacs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic [7:0]  image_cel_o,
  input wire logic [7:0]  anim_frame_o,
  input wire logic [23:0] total_time_o,
  input wire logic        status_o
);

  logic [3:0] pend_q;

  // words taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= '0;
    else pend_q <= pend_q + 4'(start && !busy) - 4'(done_o);
  end

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> pend_q != 4'd0)
    else $error("result without a pending word");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (image_cel_o == 8'd0 && anim_frame_o == 8'd0 &&
                              total_time_o == 24'd0))
    else $error("error result carries data");

  a_clear_busy: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> busy)
    else $error("not busy during clearing pass");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 4'd3)
    else $error("too many words in flight");

endmodule

bind sprite_animation_cel_select sacs_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .image_cel_o  (image_cel_o),
  .anim_frame_o (anim_frame_o),
  .total_time_o (total_time_o),
  .status_o     (status_o)
);
`default_nettype wire

// File: bench/tb_sprite_animation_cel_select.sv
// testbench for the sprite animation cel selector: prediction, checking and stimulus
`timescale 1ns / 100ps
module tb_sprite_animation_cel_select;
  import sacs_pkg::*;

  localparam int MAX_FRAMES = 256;
  localparam int WATCHDOG_LIMIT = 6000;

  // one result word as the block shows it
  typedef struct {
    logic [7:0]  cel;
    logic [7:0]  frame;
    logic [23:0] total;
    logic        status;
  } cel_word_t;

  // scoreboard: keeps its own copy of the registers and the delay memory
  class cel_select_scoreboard;
    logic [1:0]  anim_mode;
    logic [15:0] frame_delay;
    logic [7:0]  cel_count;
    logic [15:0] begin_delay;
    logic [15:0] end_delay;
    logic [15:0] delay_mem [MAX_FRAMES];
    bit          delays_present;
    int unsigned frames_in_use;
    logic [23:0] pass_total;
    bit          prepared;
    bit          mirror_on;
    int unsigned mirror_cels;
    cel_word_t   pending_words [$];
    int          mismatches;
    int          words_checked;

    function new();
      anim_mode = 0;
      frame_delay = 1;
      cel_count = 1;
      begin_delay = 0;
      end_delay = 0;
      foreach (delay_mem[i]) delay_mem[i] = 0;
      delays_present = 0;
      frames_in_use = 0;
      pass_total = 0;
      prepared = 0;
      mirror_on = 0;
      mirror_cels = 1;
      mismatches = 0;
      words_checked = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [15:0] data);
      case (idx)
        REG_ANIM_MODE:   anim_mode = data[1:0];
        REG_FRAME_DELAY: frame_delay = data;
        REG_CEL_COUNT:   cel_count = data[7:0];
        REG_BEGIN_DELAY: begin_delay = data;
        REG_END_DELAY:   end_delay = data;
        default: ;
      endcase
    endfunction

    function int unsigned uniform_delay();
      return (frame_delay == 0) ? 1 : frame_delay;
    endfunction

    // set-up step: frame count, begin/end delays, fill and sum
    function void prepare_pass();
      int unsigned n;
      int unsigned fd;
      bit pp;
      int unsigned frames;
      longint unsigned sum;
      n = (cel_count == 0) ? 1 : cel_count;
      fd = uniform_delay();
      pp = (anim_mode == MODE_PINGPONG) && (n > 1);
      frames = pp ? (2 * n - 2) : n;
      if (frames > MAX_FRAMES) frames = MAX_FRAMES;
      sum = 0;
      if (begin_delay != 0) begin
        delay_mem[0] = begin_delay;
        delays_present = 1;
      end
      if (end_delay != 0) begin
        delay_mem[frames - 1] = end_delay;
        delays_present = 1;
      end
      if (delays_present) begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
          if (i >= frames) delay_mem[i] = 0;
          else begin
            if (delay_mem[i] == 0) delay_mem[i] = fd[15:0];
            sum += delay_mem[i];
          end
        end
      end else begin
        sum = longint'(fd) * frames;
      end
      pass_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[23:0];
      frames_in_use = frames;
      mirror_on = pp;
      mirror_cels = n;
      prepared = 1;
    endfunction

    // accepted input word: update state and queue the expected result
    function void note_word(cmd_e cmd, logic [7:0] idx, logic [15:0] val, logic [31:0] t);
      cel_word_t exp_w;
      longint unsigned acc;
      longint unsigned tt;
      int unsigned frame;
      exp_w.cel = 0;
      exp_w.frame = 0;
      exp_w.status = 0;
      case (cmd)
        CMD_WRITE: begin
          delay_mem[idx] = val;
          delays_present = 1;
        end
        CMD_PREPARE: prepare_pass();
        CMD_QUERY: begin
          if (!prepared || pass_total == 0 || frames_in_use == 0) begin
            exp_w.status = 1;
          end else begin
            tt = t;
            if (anim_mode == MODE_ONCE && tt >= pass_total) begin
              frame = frames_in_use - 1;
            end else begin
              tt = tt % pass_total;
              if (delays_present) begin
                // walk the delays; running off the end picks the last frame
                acc = 0;
                frame = frames_in_use - 1;
                for (int i = 0; i < frames_in_use; i++) begin
                  acc += delay_mem[i];
                  if (acc > tt) begin
                    frame = i;
                    break;
                  end
                end
              end else begin
                frame = (tt / uniform_delay()) % frames_in_use;
              end
            end
            exp_w.frame = frame[7:0];
            if (mirror_on && frame >= mirror_cels) frame = 2 * mirror_cels - 2 - frame;
            exp_w.cel = frame[7:0];
          end
        end
        default: ;
      endcase
      exp_w.total = exp_w.status ? 24'd0 : pass_total;
      pending_words.insert(pending_words.size(), exp_w);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_word(cel_word_t got);
      cel_word_t want;
      words_checked++;
      if (pending_words.size() == 0) begin
        report("unexpected result word, cel", 32'(got.cel), 32'd0);
        return;
      end
      want = pending_words.pop_front();
      if (got.cel !== want.cel) report("image_cel", 32'(got.cel), 32'(want.cel));
      if (got.frame !== want.frame) report("anim_frame", 32'(got.frame), 32'(want.frame));
      if (got.total !== want.total) report("total_time", 32'(got.total), 32'(want.total));
      if (got.status !== want.status) report("status", 32'(got.status), 32'(want.status));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  cmd_i;
  logic [7:0]  entry_index_i;
  logic [15:0] delay_value_i;
  logic [31:0] query_time_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        done_o;
  logic [7:0]  image_cel_o;
  logic [7:0]  anim_frame_o;
  logic [23:0] total_time_o;
  logic        status_o;

  cel_select_scoreboard cel_sb;
  int words_sent;
  int quiet_cycles;

  sprite_animation_cel_select #(.MAX_FRAMES(MAX_FRAMES)) dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .entry_index_i, .delay_value_i,
    .query_time_i, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .done_o, .image_cel_o, .anim_frame_o, .total_time_o, .status_o
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // monitor: inputs and outputs are sampled at the edge, before the new drive lands
  always @(posedge clk_i) begin
    cel_word_t got;
    bit        moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (start && !busy) begin
        cel_sb.note_word(cmd_e'(cmd_i), entry_index_i, delay_value_i, query_time_i);
        words_sent++;
        moved = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) moved = 1'b1;
      if (done_o) begin
        got.cel = image_cel_o;
        got.frame = anim_frame_o;
        got.total = total_time_o;
        got.status = status_o;
        cel_sb.check_word(got);
        moved = 1'b1;
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // one command word; start stays high afterwards so back-to-back words need no dip
  task send_word(cmd_e cmd, logic [7:0] idx, logic [15:0] val, logic [31:0] t);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= cmd;
    entry_index_i <= idx;
    delay_value_i <= val;
    query_time_i <= t;
    do @(posedge clk_i); while (busy);
  endtask

  // sender holds off until every expected word is back and the engine settles
  task drain_block();
    start <= 1'b0;
    @(posedge clk_i);
    while (cel_sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task write_reg(reg_idx_e idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cel_sb.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // a 16-bit value biased toward the ends of its range
  function logic [15:0] pick_ticks();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 8));
      default: return 16'($urandom);
    endcase
  endfunction

  function logic [31:0] pick_time();
    int unsigned span;
    span = 2 * cel_sb.pass_total + 2;
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      3: return 32'(cel_sb.pass_total);
      default: return $urandom_range(0, span);
    endcase
  endfunction

  task query_word();
    send_word(CMD_QUERY, 8'($urandom), 16'($urandom), pick_time());
  endtask

  // one phase: new settings, a prepare, then mostly queries mixed with write/prepare sequences and no-ops
  task run_phase(logic [1:0] mode, logic [15:0] fd, logic [7:0] cels,
                 logic [15:0] bd, logic [15:0] ed, bit with_writes, int n_words);
    int frames_hint;
    write_reg(REG_ANIM_MODE, {14'd0, mode});
    write_reg(REG_FRAME_DELAY, fd);
    write_reg(REG_CEL_COUNT, {8'd0, cels});
    write_reg(REG_BEGIN_DELAY, bd);
    write_reg(REG_END_DELAY, ed);
    // queries against the previous prepare see the new mode but the old mirror
    repeat ($urandom_range(0, 2)) query_word();
    send_word(CMD_PREPARE, 8'($urandom), 16'($urandom), $urandom);
    for (int k = 0; k < n_words; k++) begin
      frames_hint = (cel_sb.frames_in_use > 0) ? cel_sb.frames_in_use : 1;
      case ($urandom_range(0, 19))
        0: send_word(CMD_NOP, 8'($urandom), 16'($urandom), $urandom);
        1, 2: begin
          if (with_writes) begin
            repeat ($urandom_range(1, 4)) begin
              send_word(CMD_WRITE,
                        ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                    : 8'($urandom_range(0, frames_hint)),
                        pick_ticks(), $urandom);
              k++;
            end
          end
          send_word(CMD_PREPARE, 8'($urandom), 16'($urandom), $urandom);
        end
        default: query_word();
      endcase
    end
    drain_block();
  endtask

  initial begin
    cel_sb = new();
    words_sent = 0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = CMD_NOP;
    entry_index_i = '0;
    delay_value_i = '0;
    query_time_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_ANIM_MODE;
    cfg_data_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: query before any prepare, no-op, uniform path at reset settings
    send_word(CMD_QUERY, 8'd0, 16'd0, 32'd5);
    send_word(CMD_NOP, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(CMD_PREPARE, 8'd0, 16'd0, 32'd0);
    send_word(CMD_QUERY, 8'd0, 16'd0, 32'd0);
    send_word(CMD_QUERY, 8'd0, 16'd0, 32'hFFFF_FFFF);
    drain_block();

    // uniform path only lasts until the first stored delay
    run_phase(MODE_LOOP, 16'd3, 8'd5, 16'd0, 16'd0, 0, 40);
    run_phase(MODE_ONCE, 16'd0, 8'd0, 16'd0, 16'd0, 0, 30);
    run_phase(MODE_PINGPONG, 16'd7, 8'd4, 16'd0, 16'd0, 0, 40);
    run_phase(MODE_RSVD, 16'hFFFF, 8'd128, 16'd0, 16'd0, 0, 25);
    // pingpong with 255 cels clamps frames, and the total lands just below saturation
    run_phase(MODE_PINGPONG, 16'hFFFF, 8'd255, 16'd0, 16'd0, 0, 25);

    // directed delay table: extremes of index and value, zero delay write
    send_word(CMD_WRITE, 8'd0, 16'hFFFF, 32'd0);
    send_word(CMD_WRITE, 8'd255, 16'd0, 32'd0);
    send_word(CMD_WRITE, 8'd1, 16'd0, 32'd0);
    send_word(CMD_PREPARE, 8'd0, 16'd0, 32'd0);
    send_word(CMD_QUERY, 8'd0, 16'd0, 32'hFFFF_FFFF);
    send_word(CMD_QUERY, 8'd0, 16'd0, 32'd0);
    drain_block();

    for (int ph = 0; ph < 12; ph++) begin
      run_phase(2'($urandom_range(0, 3)), pick_ticks(),
                (ph % 4 == 0) ? 8'($urandom) : 8'($urandom_range(0, 8)),
                ($urandom_range(0, 1) == 0) ? 16'd0 : pick_ticks(),
                ($urandom_range(0, 1) == 0) ? 16'd0 : pick_ticks(), 1, 85);
    end
    run_phase(MODE_ONCE, 16'hFFFF, 8'd128, 16'hFFFF, 16'hFFFF, 1, 40);
    run_phase(MODE_PINGPONG, 16'd0, 8'd0, 16'd0, 16'd0, 1, 40);
    run_phase(MODE_PINGPONG, 16'd1, 8'd2, 16'd1, 16'd1, 1, 60);

    drain_block();
    repeat (20) @(posedge clk_i);
    $display("ran %0d command words through 20 register settings, %0d result words checked",
             words_sent, cel_sb.words_checked);
    $display("covered uniform and table paths, loop/once/pingpong modes, %0d mismatches",
             cel_sb.mismatches);
    if (cel_sb.mismatches == 0 && cel_sb.pending_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
